// ----- hw/rtl/unbounded_knapsack_max_profit_macros.svh -----
// Assertion macros for the unbounded knapsack profit engine.
`ifndef UNBOUNDED_KNAPSACK_MAX_PROFIT_MACROS_SVH
`define UNBOUNDED_KNAPSACK_MAX_PROFIT_MACROS_SVH

// Consequent checked in the same cycle.
`define UKP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the following cycle.
`define UKP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ukp_pkg.sv -----
// Shared constants and types for the unbounded knapsack profit engine.
`default_nettype none

package ukp_pkg;

    localparam int MAX_CAPACITY = 1024;
    localparam int TBL_DEPTH    = MAX_CAPACITY + 1;
    localparam int TBL_AW       = $clog2(TBL_DEPTH);

    localparam int LEN_W    = 11;
    localparam int PRICE_W  = 16;
    localparam int CAP_W    = 11;
    localparam int PROFIT_W = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET    = 11'd1024;
    localparam logic             REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_RD,
        ST_RES
    } ukp_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ukp_ram.sv -----
// Generic RAM: one write port, two registered read ports, read-first.
`default_nettype none

module ukp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/unbounded_knapsack_max_profit.sv -----
// Top level of the unbounded knapsack (rod cutting) profit engine.
// Pieces stream in one item at a time; each updates a 1025-entry profit table held in a
// RAM, walking capacities from the piece length up to the configured capacity (clamped
// to 1024), one entry per cycle through a single add/saturate/compare unit. No walk is
// made when the piece is zero-length or longer than the capacity; a first-flagged item
// adds a clearing pass over all 1025 table entries. After reset the same clearing pass
// runs before s_tready rises. A last-flagged item produces one result item on the m_ side
// holding the best profit at the capacity; configuration writes are taken at any time.
`default_nettype none

module unbounded_knapsack_max_profit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,  // piece_length, piece_price
    input  wire logic                          s_tuser,  // first_piece
    input  wire logic                          s_tlast,  // last_piece
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [31:0]                   m_tdata,  // best_profit
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ukp_pkg::APB_AW-1:0]    paddr,
    input  wire logic [ukp_pkg::APB_DW-1:0]    pwdata,
    output logic      [ukp_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    import ukp_pkg::*;

    ukp_state_t state_reg, state_next;

    logic [CAP_W-1:0]    capacity_reg;
    logic [TBL_AW-1:0]   cap_eff;
    logic [TBL_AW-1:0]   clr_addr_reg;
    logic                clr_item_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic                last_reg;
    logic [TBL_AW-1:0]   wc_reg;
    logic [PROFIT_W-1:0] prev_reg;
    logic                m_tvalid_reg;
    logic [PROFIT_W-1:0] best_reg;

    logic                ram_we;
    logic [TBL_AW-1:0]   ram_waddr;
    logic [PROFIT_W-1:0] ram_wdata;
    logic [TBL_AW-1:0]   ram_raddr_a;
    logic [TBL_AW-1:0]   ram_raddr_b;
    logic [PROFIT_W-1:0] ram_rdata_a;
    logic [PROFIT_W-1:0] ram_rdata_b;

    logic                in_accept;
    logic                cfg_write;
    logic                walk_ok;
    logic                out_free;
    logic [PROFIT_W-1:0] base_val;
    logic [PROFIT_W:0]   sum_wide;
    logic [PROFIT_W-1:0] take_val;
    logic [PROFIT_W-1:0] new_val;

    assign in_accept = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_reg) : '0;

    assign cap_eff  = (capacity_reg > CAP_W'(MAX_CAPACITY)) ? TBL_AW'(MAX_CAPACITY)
                                                            : TBL_AW'(capacity_reg);
    assign walk_ok  = (len_reg != '0) && (TBL_AW'(len_reg) <= cap_eff);
    assign out_free = !m_tvalid_reg || m_tready;

    // len 1: the entry below was written last cycle and the RAM still returns old data
    assign base_val = ((len_reg == LEN_W'(1)) && (wc_reg != TBL_AW'(len_reg))) ? prev_reg
                                                                               : ram_rdata_a;
    assign sum_wide = {1'b0, base_val} + (PROFIT_W + 1)'(price_reg);
    assign take_val = sum_wide[PROFIT_W] ? '1 : sum_wide[PROFIT_W-1:0];
    assign new_val  = (take_val > ram_rdata_b) ? take_val : ram_rdata_b;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = best_reg;

    ukp_ram #(
        .WIDTH (PROFIT_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == TBL_AW'(TBL_DEPTH - 1))
                begin
                    state_next = clr_item_reg ? ST_START : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = s_tuser ? ST_CLEAR : ST_START;
                end
            end
            ST_START:
            begin
                state_next = walk_ok ? ST_WALK : ST_RD;
            end
            ST_WALK:
            begin
                if (wc_reg == cap_eff)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = wc_reg;
        ram_wdata   = new_val;
        ram_raddr_a = cap_eff;
        ram_raddr_b = cap_eff;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_START:
            begin
                ram_raddr_a = '0;
                ram_raddr_b = TBL_AW'(len_reg);
            end
            ST_WALK:
            begin
                ram_we      = 1'b1;
                ram_raddr_a = wc_reg + TBL_AW'(1) - TBL_AW'(len_reg);
                ram_raddr_b = wc_reg + TBL_AW'(1);
            end
            default:
            begin
                ram_raddr_a = cap_eff;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
            capacity_reg <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && (paddr[2] == REG_CAPACITY))
            begin
                capacity_reg <= pwdata[CAP_W-1:0];
            end
            if (in_accept)
            begin
                clr_addr_reg <= '0;
                clr_item_reg <= 1'b1;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + TBL_AW'(1);
            end
            if ((state_reg == ST_RES) && last_reg && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            len_reg   <= s_tdata[LEN_W-1:0];
            price_reg <= s_tdata[LEN_W+PRICE_W-1:LEN_W];
            last_reg  <= s_tlast;
        end
        if (state_reg == ST_START)
        begin
            wc_reg <= TBL_AW'(len_reg);
        end
        else if (state_reg == ST_WALK)
        begin
            wc_reg   <= wc_reg + TBL_AW'(1);
            prev_reg <= new_val;
        end
        if ((state_reg == ST_RES) && last_reg && out_free)
        begin
            best_reg <= ram_rdata_a;
        end
    end

`include "unbounded_knapsack_max_profit_macros.svh"

    `UKP_ASSERT_NOW(a_walk_in_range, (state_reg == ST_WALK) && ram_we, wc_reg <= cap_eff, "table write beyond capacity")
    `UKP_ASSERT_NEXT(a_first_clears, in_accept && s_tuser, (state_reg == ST_CLEAR) && (clr_addr_reg == '0), "first item did not start clearing pass")
    `UKP_ASSERT_NOW(a_result_source, $rose(m_tvalid_reg), $past((state_reg == ST_RES) && last_reg), "result not from a last item")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the unbounded knapsack profit engine.
`timescale 1ns / 1ps

module tb_top;
    import ukp_pkg::*;

    localparam int SETTLE_CYCLES = 2200;
    localparam int STALL_LIMIT   = 20000;
    localparam logic [APB_AW-1:0] ADDR_CAPACITY = APB_AW'(4 * REG_CAPACITY);

    typedef struct {
        logic [LEN_W-1:0]    len;
        logic [PRICE_W-1:0]  price;
        bit                  first;
        bit                  last;
        bit                  pinned;
        logic [PROFIT_W-1:0] want;
    } piece_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;   // piece_length, piece_price, zero pad
    logic              s_tuser = 1'b0; // first_piece
    logic              s_tlast = 1'b0; // last_piece
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;        // best_profit
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic [PROFIT_W-1:0] profit_tbl [0:MAX_CAPACITY] = '{default: '0};
    logic [CAP_W-1:0]    cap_reg = CAP_RESET;
    logic [PROFIT_W-1:0] best_q [$];
    longint              pinned_q [$];
    logic [PROFIT_W-1:0] want_profit;
    int                  errors = 0;
    int                  stall_cnt = 0;
    int                  tx_idle_pct = 28;
    int                  rx_idle_pct = 53;

    piece_row_t rows [14] = '{
        '{1,    0,     0, 1, 1, 0},
        '{1024, 65535, 1, 1, 1, 65535},
        '{1,    65535, 1, 1, 1, 67107840},
        '{0,    65535, 1, 1, 1, 0},
        '{2047, 65535, 1, 1, 1, 0},
        '{1025, 100,   1, 1, 1, 0},
        '{3,    10,    1, 0, 0, 0},
        '{5,    17,    0, 0, 0, 0},
        '{0,    9,     0, 0, 0, 0},
        '{1024, 40000, 0, 1, 0, 0},
        '{2,    21845, 0, 1, 0, 0},
        '{7,    43690, 1, 0, 0, 0},
        '{1023, 1,     0, 0, 0, 0},
        '{682,  12345, 0, 1, 0, 0}
    };

    unbounded_knapsack_max_profit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // Ascending walk lets a piece feed later entries of the same pass.
    function automatic void apply_piece(logic [LEN_W-1:0] len, logic [PRICE_W-1:0] price,
                                        bit first, bit last);
        int                  eff;
        logic [PROFIT_W:0]   sum;
        logic [PROFIT_W-1:0] take;
        logic [PROFIT_W-1:0] val;
        longint              pin;
        eff = (cap_reg > MAX_CAPACITY) ? MAX_CAPACITY : int'(cap_reg);
        if (first)
        begin
            for (int i = 0; i <= MAX_CAPACITY; i++)
                profit_tbl[i] = '0;
        end
        if (len != 0 && int'(len) <= eff)
        begin
            for (int c = int'(len); c <= eff; c++)
            begin
                sum  = {1'b0, profit_tbl[c - int'(len)]} + {17'b0, price};
                take = sum[PROFIT_W] ? '1 : sum[PROFIT_W-1:0];
                if (take > profit_tbl[c])
                    profit_tbl[c] = take;
            end
        end
        if (last)
        begin
            val = profit_tbl[eff];
            if (pinned_q.size() > 0)
            begin
                pin = pinned_q.pop_front();
                if (pin >= 0)
                    val = pin[PROFIT_W-1:0];
            end
            best_q.push_back(val);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (best_q.size() == 0)
                    flag_mismatch("result with none pending", m_tdata, 0);
                else
                begin
                    want_profit = best_q.pop_front();
                    if (m_tdata !== want_profit)
                        flag_mismatch("best_profit", m_tdata, want_profit);
                end
            end
            if (s_tvalid && s_tready)
                apply_piece(s_tdata[10:0], s_tdata[26:11], s_tuser, s_tlast);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Called and returns at a falling edge.
    task automatic send_piece(logic [LEN_W-1:0] len, logic [PRICE_W-1:0] price,
                              bit first, bit last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, price, len};
        s_tuser  <= first;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    task automatic apb_xfer(bit wr, logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr)
            cap_reg = wdata[CAP_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait for every pending result, then for the longest item to finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (best_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_capacity(int value);
        logic [APB_DW-1:0] rd;
        settle();
        apb_xfer(1'b1, APB_DW'(value), rd);
        apb_xfer(1'b0, '0, rd);
        if (rd !== APB_DW'(cap_reg))
            flag_mismatch("capacity readback", rd, APB_DW'(cap_reg));
    endtask

    // Mostly first..last sequences with random content, some broken ones and noise.
    task automatic run_phase(int cap_val, int n_items, int tx, int rx);
        int                 done;
        int                 seq_len;
        int                 eff;
        int                 r;
        bit                 broken;
        bit                 first;
        bit                 last;
        logic [LEN_W-1:0]   len;
        logic [PRICE_W-1:0] price;
        set_capacity(cap_val);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        eff  = (cap_val > MAX_CAPACITY) ? MAX_CAPACITY : cap_val;
        done = 0;
        while (done < n_items)
        begin
            seq_len = $urandom_range(1, 8);
            broken  = ($urandom_range(0, 99) < 20);
            for (int k = 0; k < seq_len; k++)
            begin
                if ($urandom_range(0, 99) < 8 || eff == 0)
                    len = LEN_W'($urandom_range(0, 2047));
                else
                    len = LEN_W'($urandom_range(1, eff));
                r = $urandom_range(0, 99);
                if (r < 10)
                    price = '1;
                else if (r < 20)
                    price = '0;
                else if (r < 50)
                    price = PRICE_W'($urandom_range(0, 255));
                else
                    price = PRICE_W'($urandom_range(0, 65535));
                if (broken)
                begin
                    first = ($urandom_range(0, 3) == 0);
                    last  = ($urandom_range(0, 3) == 0);
                end
                else
                begin
                    first = (k == 0);
                    last  = (k == seq_len - 1);
                end
                done++;
                send_piece(len, price, first, last);
            end
        end
    endtask

    initial
    begin
        logic [APB_DW-1:0] rd;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        apb_xfer(1'b0, '0, rd);
        if (rd !== APB_DW'(CAP_RESET))
            flag_mismatch("capacity after reset", rd, APB_DW'(CAP_RESET));

        foreach (rows[i])
        begin
            if (rows[i].last)
                pinned_q.push_back(rows[i].pinned ? longint'(rows[i].want) : -1);
            send_piece(rows[i].len, rows[i].price, rows[i].first, rows[i].last);
        end

        run_phase(48,   120, 28, 53);
        run_phase(2047, 50,  28, 53);
        run_phase(1,    60,  53, 28);
        run_phase(0,    40,  53, 28);
        run_phase(300,  120, 53, 28);
        run_phase(1024, 50,  0,  0);
        run_phase(7,    130, 0,  0);

        settle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
